// File: design/pedal_plausibility_checker_assert.svh
// Assertion macros for the pedal plausibility checker.
// Both macros sample on the rising edge of i_clk in the module that uses them.
`ifndef PEDAL_PLAUSIBILITY_CHECKER_ASSERT_SVH
`define PEDAL_PLAUSIBILITY_CHECKER_ASSERT_SVH

// Checked only outside reset.
`define PPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked during reset as well.
`define PPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/ppc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

    localparam int ADC_BITS  = 12;
    localparam int GAIN_BITS = 16;
    localparam int PCT_BITS  = 7;
    localparam int POS_BITS  = 8;
    localparam int TIME_BITS = 32;
    localparam int LIM_BITS  = 7;

    localparam logic [PCT_BITS-1:0] PCT_MAX = 7'd100;

    // register index, paddr[4:2]
    localparam logic [2:0] REG_PEDAL_A_MIN      = 3'd0;
    localparam logic [2:0] REG_PEDAL_A_GAIN     = 3'd1;
    localparam logic [2:0] REG_PEDAL_B_MIN      = 3'd2;
    localparam logic [2:0] REG_PEDAL_B_GAIN     = 3'd3;
    localparam logic [2:0] REG_SPREAD_LIMIT     = 3'd4;
    localparam logic [2:0] REG_CONFIRM_TIME_US  = 3'd5;
    localparam logic [2:0] REG_BRAKE_LOW_CODE   = 3'd6;
    localparam logic [2:0] REG_BRAKE_PRESS_CODE = 3'd7;

    // output codes
    localparam logic [1:0] PHASE_WAIT_BRAKE  = 2'd0;
    localparam logic [1:0] PHASE_BUZZING     = 2'd1;
    localparam logic [1:0] PHASE_WAIT_SWITCH = 2'd2;
    localparam logic [1:0] PHASE_RUNNING     = 2'd3;
    localparam logic [1:0] STATUS_GOOD       = 2'd0;
    localparam logic [1:0] STATUS_PENDING    = 2'd1;
    localparam logic [1:0] STATUS_CONFIRMED  = 2'd2;

    typedef enum logic [3:0] {
        PH_WAIT_BRAKE  = 4'b0001,
        PH_BUZZING     = 4'b0010,
        PH_WAIT_SWITCH = 4'b0100,
        PH_RUNNING     = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        FL_GOOD      = 3'b001,
        FL_PENDING   = 3'b010,
        FL_CONFIRMED = 3'b100
    } t_fault;

    typedef struct packed {
        logic [ADC_BITS-1:0]  pedal_a_code;
        logic [ADC_BITS-1:0]  pedal_b_code;
        logic [ADC_BITS-1:0]  brake_code;
        logic                 switch_on;
        logic [TIME_BITS-1:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          phase;
        logic                buzzer_on;
        logic [1:0]          pedal_status;
        logic [1:0]          brake_status;
        logic                position_valid;
        logic [POS_BITS-1:0] position_x2;
    } t_out_item;

    typedef struct packed {
        logic [ADC_BITS-1:0]  pedal_a_min;
        logic [GAIN_BITS-1:0] pedal_a_gain;
        logic [ADC_BITS-1:0]  pedal_b_min;
        logic [GAIN_BITS-1:0] pedal_b_gain;
        logic [LIM_BITS-1:0]  spread_limit;
        logic [TIME_BITS-1:0] confirm_time_us;
        logic [ADC_BITS-1:0]  brake_low_code;
        logic [ADC_BITS-1:0]  brake_press_code;
    } t_cfg;

    function automatic logic [1:0] phase_code(t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_WAIT_BRAKE:  code = PHASE_WAIT_BRAKE;
            PH_BUZZING:     code = PHASE_BUZZING;
            PH_WAIT_SWITCH: code = PHASE_WAIT_SWITCH;
            PH_RUNNING:     code = PHASE_RUNNING;
            default:        code = PHASE_WAIT_BRAKE;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] fault_code(t_fault fl);
        logic [1:0] code;
        unique case (fl)
            FL_GOOD:      code = STATUS_GOOD;
            FL_PENDING:   code = STATUS_PENDING;
            FL_CONFIRMED: code = STATUS_CONFIRMED;
            default:      code = STATUS_GOOD;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: design/ppc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppc_in_if;
    logic              valid;
    logic              ready;
    ppc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppc_out_if;
    logic               valid;
    logic               ready;
    ppc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/ppc_scale.sv
`timescale 1ns / 1ps
`default_nettype none

// code -> whole percent: round((code - min) * gain / 2^16), clamped to 0..100
module ppc_scale (
    input  wire logic [ppc_pkg::ADC_BITS-1:0]  i_code,
    input  wire logic [ppc_pkg::ADC_BITS-1:0]  i_min,
    input  wire logic [ppc_pkg::GAIN_BITS-1:0] i_gain,
    output logic      [ppc_pkg::PCT_BITS-1:0]  o_pct
);
    localparam int PROD_BITS = ppc_pkg::ADC_BITS + ppc_pkg::GAIN_BITS;
    localparam int Q_BITS    = PROD_BITS + 1 - ppc_pkg::GAIN_BITS;

    logic [ppc_pkg::ADC_BITS-1:0] diff;
    logic [PROD_BITS-1:0]         prod;
    logic [PROD_BITS:0]           rounded;
    logic [Q_BITS-1:0]            quot;

    assign diff    = i_code - i_min;
    assign prod    = PROD_BITS'(diff) * PROD_BITS'(i_gain);
    assign rounded = {1'b0, prod} + (PROD_BITS + 1)'(1 << (ppc_pkg::GAIN_BITS - 1));
    assign quot    = rounded[PROD_BITS:ppc_pkg::GAIN_BITS];

    always_comb begin
        if (i_code <= i_min) begin
            o_pct = '0;
        end else if (quot > Q_BITS'(ppc_pkg::PCT_MAX)) begin
            o_pct = ppc_pkg::PCT_MAX;
        end else begin
            o_pct = quot[ppc_pkg::PCT_BITS-1:0];
        end
    end
endmodule

`default_nettype wire

// File: design/pedal_plausibility_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Modport   Payload
// i_in      in   sink      ppc_pkg::t_in_item  (sensor sample + timestamp)
// o_out     out  source    ppc_pkg::t_out_item (phase, status, position)
// APB       in   slave     8 x 32-bit config registers at 4*i
//
// One sample per cycle while o_out is not stalled: input register, one pass of
// compare/scale logic, result register. Output valid rises when the sample moves
// from the input register to the result register; it can then transfer.
// The two 12x16 scaling multiplies feed the spread compare in that one pass.
// Stalls on o_out back up through the input register; reset (sync, low)
// restores the config defaults and returns to waiting for brake.
module pedal_plausibility_checker #(
    parameter int unsigned BUZZ_TIME_US = 1000000
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ppc_in_if.sink           i_in,
    ppc_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam logic [ppc_pkg::TIME_BITS-1:0] BUZZ_TIME = ppc_pkg::TIME_BITS'(BUZZ_TIME_US);

    ppc_pkg::t_cfg      r_cfg;
    logic               r_in_valid;
    ppc_pkg::t_in_item  r_in;
    logic               r_out_valid;
    ppc_pkg::t_out_item r_out;
    ppc_pkg::t_out_item n_out;

    ppc_pkg::t_phase r_phase, n_phase;
    ppc_pkg::t_fault r_pf, n_pf, r_bf, n_bf;
    logic [ppc_pkg::TIME_BITS-1:0] r_buzz_start, n_buzz_start;
    logic [ppc_pkg::TIME_BITS-1:0] r_pf_start, n_pf_start;
    logic [ppc_pkg::TIME_BITS-1:0] r_bf_start, n_bf_start;

    logic                          advance;
    logic [2:0]                    reg_idx;
    logic [ppc_pkg::PCT_BITS-1:0]  pct_a, pct_b, spread;
    logic [ppc_pkg::TIME_BITS-1:0] buzz_elapsed, pf_elapsed, bf_elapsed;
    logic                          pf_timeout, bf_timeout;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_comb begin
        unique case (reg_idx)
            ppc_pkg::REG_PEDAL_A_MIN:      prdata = 32'(r_cfg.pedal_a_min);
            ppc_pkg::REG_PEDAL_A_GAIN:     prdata = 32'(r_cfg.pedal_a_gain);
            ppc_pkg::REG_PEDAL_B_MIN:      prdata = 32'(r_cfg.pedal_b_min);
            ppc_pkg::REG_PEDAL_B_GAIN:     prdata = 32'(r_cfg.pedal_b_gain);
            ppc_pkg::REG_SPREAD_LIMIT:     prdata = 32'(r_cfg.spread_limit);
            ppc_pkg::REG_CONFIRM_TIME_US:  prdata = r_cfg.confirm_time_us;
            ppc_pkg::REG_BRAKE_LOW_CODE:   prdata = 32'(r_cfg.brake_low_code);
            ppc_pkg::REG_BRAKE_PRESS_CODE: prdata = 32'(r_cfg.brake_press_code);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pedal_a_min      <= 12'd310;
            r_cfg.pedal_a_gain     <= 16'd2640;
            r_cfg.pedal_b_min      <= 12'd372;
            r_cfg.pedal_b_gain     <= 16'd2201;
            r_cfg.spread_limit     <= 7'd10;
            r_cfg.confirm_time_us  <= 32'd100000;
            r_cfg.brake_low_code   <= 12'd620;
            r_cfg.brake_press_code <= 12'd3276;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                ppc_pkg::REG_PEDAL_A_MIN:      r_cfg.pedal_a_min      <= pwdata[11:0];
                ppc_pkg::REG_PEDAL_A_GAIN:     r_cfg.pedal_a_gain     <= pwdata[15:0];
                ppc_pkg::REG_PEDAL_B_MIN:      r_cfg.pedal_b_min      <= pwdata[11:0];
                ppc_pkg::REG_PEDAL_B_GAIN:     r_cfg.pedal_b_gain     <= pwdata[15:0];
                ppc_pkg::REG_SPREAD_LIMIT:     r_cfg.spread_limit     <= pwdata[6:0];
                ppc_pkg::REG_CONFIRM_TIME_US:  r_cfg.confirm_time_us  <= pwdata;
                ppc_pkg::REG_BRAKE_LOW_CODE:   r_cfg.brake_low_code   <= pwdata[11:0];
                ppc_pkg::REG_BRAKE_PRESS_CODE: r_cfg.brake_press_code <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // ---------------- step logic ----------------
    ppc_scale u_scale_a (
        .i_code (r_in.pedal_a_code),
        .i_min  (r_cfg.pedal_a_min),
        .i_gain (r_cfg.pedal_a_gain),
        .o_pct  (pct_a)
    );

    ppc_scale u_scale_b (
        .i_code (r_in.pedal_b_code),
        .i_min  (r_cfg.pedal_b_min),
        .i_gain (r_cfg.pedal_b_gain),
        .o_pct  (pct_b)
    );

    assign spread       = (pct_a > pct_b) ? pct_a - pct_b : pct_b - pct_a;
    assign buzz_elapsed = r_in.now_us - r_buzz_start;
    assign pf_elapsed   = r_in.now_us - r_pf_start;
    assign bf_elapsed   = r_in.now_us - r_bf_start;
    // a fault that starts in this step has zero elapsed time
    assign pf_timeout   = (r_pf == ppc_pkg::FL_GOOD) ? (r_cfg.confirm_time_us == '0)
                                                     : (pf_elapsed >= r_cfg.confirm_time_us);
    assign bf_timeout   = (r_bf == ppc_pkg::FL_GOOD) ? (r_cfg.confirm_time_us == '0)
                                                     : (bf_elapsed >= r_cfg.confirm_time_us);

    always_comb begin
        n_phase      = r_phase;
        n_buzz_start = r_buzz_start;
        n_pf         = r_pf;
        n_pf_start   = r_pf_start;
        n_bf         = r_bf;
        n_bf_start   = r_bf_start;
        n_out        = '0;

        unique case (r_phase)
            ppc_pkg::PH_WAIT_BRAKE: begin
                if (r_in.brake_code >= r_cfg.brake_press_code) begin
                    n_phase      = ppc_pkg::PH_BUZZING;
                    n_buzz_start = r_in.now_us;
                end
            end
            ppc_pkg::PH_BUZZING: begin
                if (buzz_elapsed >= BUZZ_TIME) begin
                    n_phase = ppc_pkg::PH_WAIT_SWITCH;
                end
            end
            ppc_pkg::PH_WAIT_SWITCH: begin
                if (r_in.switch_on) begin
                    n_phase = ppc_pkg::PH_RUNNING;
                end
            end
            ppc_pkg::PH_RUNNING: ;
            default: n_phase = ppc_pkg::PH_WAIT_BRAKE;
        endcase

        if (n_phase == ppc_pkg::PH_RUNNING) begin
            if (r_in.brake_code < r_cfg.brake_low_code) begin
                if (r_bf == ppc_pkg::FL_GOOD) begin
                    n_bf       = ppc_pkg::FL_PENDING;
                    n_bf_start = r_in.now_us;
                end
                if (r_bf != ppc_pkg::FL_CONFIRMED && bf_timeout) begin
                    n_bf = ppc_pkg::FL_CONFIRMED;
                end
            end else begin
                n_bf = ppc_pkg::FL_GOOD;
            end

            if (n_bf != ppc_pkg::FL_CONFIRMED) begin
                n_out.position_valid = 1'b1;
                n_out.position_x2    = ppc_pkg::POS_BITS'(pct_a) + ppc_pkg::POS_BITS'(pct_b);
                if (spread > r_cfg.spread_limit) begin
                    if (r_pf == ppc_pkg::FL_GOOD) begin
                        n_pf       = ppc_pkg::FL_PENDING;
                        n_pf_start = r_in.now_us;
                    end
                    if (r_pf != ppc_pkg::FL_CONFIRMED && pf_timeout) begin
                        n_pf = ppc_pkg::FL_CONFIRMED;
                    end
                    if (n_pf == ppc_pkg::FL_CONFIRMED) begin
                        n_out.position_x2 = '0;
                    end
                end else begin
                    n_pf = ppc_pkg::FL_GOOD;
                end
            end
        end

        n_out.phase        = ppc_pkg::phase_code(n_phase);
        n_out.buzzer_on    = (n_phase == ppc_pkg::PH_BUZZING);
        n_out.pedal_status = ppc_pkg::fault_code(n_pf);
        n_out.brake_status = ppc_pkg::fault_code(n_bf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ppc_pkg::PH_WAIT_BRAKE;
            r_buzz_start <= '0;
            r_pf         <= ppc_pkg::FL_GOOD;
            r_pf_start   <= '0;
            r_bf         <= ppc_pkg::FL_GOOD;
            r_bf_start   <= '0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_buzz_start <= n_buzz_start;
            r_pf         <= n_pf;
            r_pf_start   <= n_pf_start;
            r_bf         <= n_bf;
            r_bf_start   <= n_bf_start;
        end
    end
endmodule

`default_nettype wire

// File: design/ppc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "pedal_plausibility_checker_assert.svh"

module ppc_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ppc_out_if.source i_out
);
    `PPC_ASSERT_ALWAYS(a_rst_no_out, !i_rst_n |=> !i_out.valid, "output valid after reset")
    `PPC_ASSERT(a_hold_stall, i_out.valid && !i_out.ready |=> i_out.valid && $stable(i_out.data), "stalled result changed")
    `PPC_ASSERT(a_buzz_phase, i_out.valid |-> (i_out.data.buzzer_on == (i_out.data.phase == ppc_pkg::PHASE_BUZZING)), "buzzer does not follow phase")
    `PPC_ASSERT(a_pos_gate, i_out.valid && (i_out.data.position_valid == 1'b0 || i_out.data.pedal_status == ppc_pkg::STATUS_CONFIRMED) |-> i_out.data.position_x2 == '0, "position given while blocked")
    `PPC_ASSERT(a_run_only, i_out.valid && i_out.data.position_valid |-> i_out.data.phase == ppc_pkg::PHASE_RUNNING && i_out.data.brake_status != ppc_pkg::STATUS_CONFIRMED, "position outside running")
endmodule

bind pedal_plausibility_checker ppc_checker u_ppc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_out   (o_out)
);

`default_nettype wire
